### sv/x86_integer_alu_with_flags_macros.svh
// assertion macros for the x86 integer alu
`ifndef X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH

// checked on every rising clock edge outside reset
`define XALU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define XALU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/xalu_pkg.sv
// shared types and constants for the x86 integer alu
package xalu_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FIELD_BITS        = 32;
   localparam int RESULT_BITS       = 64;

   typedef enum logic [3:0] {
      KIND_ADD  = 4'd0,
      KIND_ADC  = 4'd1,
      KIND_SUB  = 4'd2,
      KIND_SBB  = 4'd3,
      KIND_AND  = 4'd4,
      KIND_OR   = 4'd5,
      KIND_XOR  = 4'd6,
      KIND_SHL  = 4'd7,
      KIND_SHR  = 4'd8,
      KIND_SAL  = 4'd9,
      KIND_SAR  = 4'd10,
      KIND_MUL  = 4'd11,
      KIND_IMUL = 4'd12
   } kind_type;

   typedef enum logic [1:0] {
      SIZE_8  = 2'd0,
      SIZE_16 = 2'd1,
      SIZE_32 = 2'd2
   } size_type;

   typedef struct packed {
      logic cf;
      logic pf;
      logic zf;
      logic sf;
      logic of;
   } flags_type;

endpackage

### sv/x86_integer_alu_with_flags.sv
// x86 integer alu with cf/pf/zf/sf/of flag register
//
//  channel  | direction | ports                                     | accepted when
//  ---------+-----------+-------------------------------------------+-------------------------
//  request  | in        | req_kind req_src req_dest req_size_sel    | req_valid && req_ready
//  response | out       | rsp_result rsp_cf rsp_pf rsp_zf rsp_sf    | rsp_valid && rsp_ready
//           |           | rsp_of                                    |
//
// one item per cycle sustained while the response is taken; an item passes the input
// register, then the result register, before it shows on the response
// the work between the registers is one 33x33 multiplier, an adder, a subtractor and a
// barrel shifter; adc/sbb read the carry that the previous item left in the
// flag register, which is updated as the item moves into the result register
// reset clears the flags and both valid bits
// a stalled response holds the result register; the input register keeps
// accepting while it can hand its item on, so one more item waits in front
module x86_integer_alu_with_flags #(
   parameter int WORD_BITS = xalu_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_kind,
   input  logic [31:0] req_src,
   input  logic [31:0] req_dest,
   input  logic [1:0]  req_size_sel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result,
   output logic        rsp_cf,
   output logic        rsp_pf,
   output logic        rsp_zf,
   output logic        rsp_sf,
   output logic        rsp_of
);
   import xalu_pkg::*;

   localparam int WB = WORD_BITS;

   // input register
   logic                   s1_valid_ff;
   logic [3:0]             kind_ff;
   logic [FIELD_BITS-1:0]  src_ff;
   logic [FIELD_BITS-1:0]  dest_ff;
   logic [1:0]             size_ff;

   // result register and flag state
   logic                   out_valid_ff;
   logic [RESULT_BITS-1:0] result_ff;
   logic [RESULT_BITS-1:0] result_in;
   flags_type              flags_ff;
   flags_type              flags_in;

   logic                   stage_go;

   // add/sub/logic datapath on the word width
   logic [WB-1:0]          add_a;
   logic [WB-1:0]          add_b;
   logic                   cin;
   logic [WB:0]            sum_w;
   logic [WB:0]            diff_w;
   logic [WB-1:0]          logic_res;

   // operand width for shifts and multiplies
   logic [5:0]             sw_sel;
   logic [5:0]             sw;
   logic [4:0]             sw_m1;
   logic [FIELD_BITS-1:0]  fmask;

   // shifter
   logic [FIELD_BITS-1:0]  fy;
   logic [FIELD_BITS-1:0]  upper;
   logic                   cnt_zero;
   logic                   in_range;
   logic                   at_width;
   logic                   sgn;
   logic [63:0]            shl_wide;
   logic [32:0]            shr_wide;
   logic [FIELD_BITS-1:0]  sar_fill;
   logic [FIELD_BITS-1:0]  sh_y;
   logic                   sh_cf;

   // multiplier
   logic [FIELD_BITS-1:0]  mul_am;
   logic [FIELD_BITS-1:0]  mul_bm;
   logic signed [32:0]     mul_a;
   logic signed [32:0]     mul_b;
   logic signed [65:0]     mul_p;
   logic [63:0]            prod;
   logic [63:0]            mask64;
   logic [63:0]            hi_bits;
   logic                   mul_big;

   // flag derivation from the width-limited field
   logic [FIELD_BITS-1:0]  fv;
   logic [5:0]             fw;
   logic [4:0]             fw_m1;
   logic [FIELD_BITS-1:0]  fw_mask;
   logic                   upd_pzs;

   // items moving into the result register, by class
   logic                   logic_go;
   logic                   mul_go;
   logic                   spare_go;
   logic [2:0]             pzs_view;

   // the input register hands on when the result register is free or draining
   assign stage_go  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (stage_go) begin
            out_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         src_ff  <= req_src;
         dest_ff <= req_dest;
         size_ff <= req_size_sel;
      end
      if (stage_go) begin
         result_ff <= result_in;
      end
   end

   // add, sub and logic
   assign add_a  = src_ff[WB-1:0];
   assign add_b  = dest_ff[WB-1:0];
   assign cin    = ((kind_ff == KIND_ADC) || (kind_ff == KIND_SBB)) ? flags_ff.cf : 1'b0;
   assign sum_w  = {1'b0, add_a} + {1'b0, add_b} + {{WB{1'b0}}, cin};
   assign diff_w = {1'b0, add_b} - {1'b0, add_a} - {{WB{1'b0}}, cin};

   always_comb begin
      unique case (kind_ff) inside
         KIND_AND: logic_res = add_a & add_b;
         KIND_OR:  logic_res = add_a | add_b;
         default:  logic_res = add_a ^ add_b;
      endcase
   end

   // width select, clamped to the word width
   always_comb begin
      unique case (size_ff)
         SIZE_8:  sw_sel = 6'd8;
         SIZE_16: sw_sel = 6'd16;
         default: sw_sel = 6'd32;
      endcase
      sw    = (sw_sel > 6'(WB)) ? 6'(WB) : sw_sel;
      sw_m1 = 5'(sw - 6'd1);
      fmask = ~({FIELD_BITS{1'b1}} << sw);
   end

   // barrel shifter on the selected field
   always_comb begin
      fy       = dest_ff & fmask;
      upper    = dest_ff & ~fmask;
      cnt_zero = (src_ff == '0);
      in_range = (src_ff < {26'd0, sw});
      at_width = (src_ff == {26'd0, sw});
      sgn      = fy[sw_m1];
      shl_wide = {32'd0, fy} << src_ff[4:0];
      // bit 0 holds the last bit shifted out to the right
      shr_wide = {fy, 1'b0} >> src_ff[4:0];
      sar_fill = sgn ? (fmask & ~(fmask >> src_ff[4:0])) : '0;
      sh_y     = fy;
      sh_cf    = flags_ff.cf;
      if (!cnt_zero) begin
         unique case (kind_ff) inside
            KIND_SHL, KIND_SAL: begin
               if (in_range) begin
                  sh_cf = shl_wide[sw];
                  sh_y  = shl_wide[31:0] & fmask;
               end else begin
                  sh_cf = at_width ? fy[0] : 1'b0;
                  sh_y  = '0;
               end
            end
            KIND_SHR: begin
               if (in_range) begin
                  sh_cf = shr_wide[0];
                  sh_y  = fy >> src_ff[4:0];
               end else begin
                  sh_cf = at_width ? fy[sw_m1] : 1'b0;
                  sh_y  = '0;
               end
            end
            default: begin
               // arithmetic right shift, sign fills the vacated bits
               if (in_range) begin
                  sh_cf = shr_wide[0];
                  sh_y  = (fy >> src_ff[4:0]) | sar_fill;
               end else begin
                  sh_cf = sgn;
                  sh_y  = sgn ? fmask : '0;
               end
            end
         endcase
      end
   end

   // one shared signed 33x33 multiplier: zero extension for mul, sign for imul
   always_comb begin
      mul_am = src_ff & fmask;
      mul_bm = dest_ff & fmask;
      if (kind_ff == KIND_IMUL) begin
         mul_a = mul_am[sw_m1] ? {1'b1, mul_am | ~fmask} : {1'b0, mul_am};
         mul_b = mul_bm[sw_m1] ? {1'b1, mul_bm | ~fmask} : {1'b0, mul_bm};
      end else begin
         mul_a = {1'b0, mul_am};
         mul_b = {1'b0, mul_bm};
      end
      mul_p   = mul_a * mul_b;
      prod    = mul_p[63:0];
      mask64  = ~({64{1'b1}} << sw);
      hi_bits = prod >> sw_m1;
      if (kind_ff == KIND_IMUL) begin
         // significant unless the high half is all copies of the sign
         mul_big = !((hi_bits == '0) || (hi_bits == ({64{1'b1}} >> sw_m1)));
      end else begin
         mul_big = ((prod & ~mask64) != '0);
      end
   end

   // operation select and flag update
   always_comb begin
      flags_in  = flags_ff;
      result_in = '0;
      fv        = '0;
      fw        = 6'(WB);
      upd_pzs   = 1'b0;
      unique case (kind_ff) inside
         KIND_ADD, KIND_ADC: begin
            result_in   = RESULT_BITS'(sum_w[WB-1:0]);
            fv          = FIELD_BITS'(sum_w[WB-1:0]);
            upd_pzs     = 1'b1;
            flags_in.cf = sum_w[WB];
            flags_in.of = ~(add_a[WB-1] ^ add_b[WB-1]) & (add_a[WB-1] ^ sum_w[WB-1]);
         end
         KIND_SUB, KIND_SBB: begin
            result_in   = RESULT_BITS'(diff_w[WB-1:0]);
            fv          = FIELD_BITS'(diff_w[WB-1:0]);
            upd_pzs     = 1'b1;
            flags_in.cf = diff_w[WB];
            flags_in.of = (add_a[WB-1] ^ add_b[WB-1]) & (add_b[WB-1] ^ diff_w[WB-1]);
         end
         KIND_AND, KIND_OR, KIND_XOR: begin
            result_in   = RESULT_BITS'(logic_res);
            fv          = FIELD_BITS'(logic_res);
            upd_pzs     = 1'b1;
            flags_in.cf = 1'b0;
            flags_in.of = 1'b0;
         end
         KIND_SHL, KIND_SHR, KIND_SAL, KIND_SAR: begin
            result_in   = {32'd0, upper | sh_y};
            fv          = sh_y;
            fw          = sw;
            upd_pzs     = 1'b1;
            flags_in.cf = sh_cf;
         end
         KIND_MUL, KIND_IMUL: begin
            result_in   = prod;
            flags_in.cf = mul_big;
            flags_in.of = mul_big;
         end
         default: begin
            // unused kinds give a zero result and leave the flags as they stand
            result_in = '0;
         end
      endcase
      fw_m1   = 5'(fw - 6'd1);
      fw_mask = ~({FIELD_BITS{1'b1}} << fw);
      if (upd_pzs) begin
         flags_in.pf = ~^fv[7:0];
         flags_in.zf = ((fv & fw_mask) == '0);
         flags_in.sf = fv[fw_m1];
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;
   assign rsp_cf     = flags_ff.cf;
   assign rsp_pf     = flags_ff.pf;
   assign rsp_zf     = flags_ff.zf;
   assign rsp_sf     = flags_ff.sf;
   assign rsp_of     = flags_ff.of;

   assign logic_go = stage_go && (kind_ff == KIND_AND || kind_ff == KIND_OR || kind_ff == KIND_XOR);
   assign mul_go   = stage_go && (kind_ff == KIND_MUL || kind_ff == KIND_IMUL);
   assign spare_go = stage_go && (kind_ff > KIND_IMUL);
   assign pzs_view = {flags_ff.pf, flags_ff.zf, flags_ff.sf};

`include "x86_integer_alu_with_flags_macros.svh"

   `XALU_ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_valid && !s1_valid_ff), "stale item")
   `XALU_ASSERT(a_ready_when_free, !out_valid_ff |-> req_ready, "stalled while empty")
   `XALU_ASSERT(a_logic_clears, logic_go |=> (!rsp_cf && !rsp_of), "logic left cf or of set")
   `XALU_ASSERT(a_mul_keeps_pzs, mul_go |=> (rsp_cf == rsp_of && $stable(pzs_view)), "pzs changed")
   `XALU_ASSERT(a_unused_kind_idle, spare_go |=> (rsp_result == '0 && $stable(flags_ff)), "spare op")

endmodule

### sim/tb_x86_integer_alu_with_flags.sv
// testbench for the x86 integer alu: directed and random items checked against a flag predictor
`timescale 1ns / 100ps

module tb_x86_integer_alu_with_flags;
   import xalu_pkg::*;

   // kinds past imul and the size selector past 32 bits are legal inputs too
   localparam logic [3:0] KIND_SPARE_FIRST = 4'd13;
   localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;
   localparam logic [1:0] SIZE_WIDE        = 2'd3;
   localparam int unsigned ALU_WORD        = WORD_BITS_DEFAULT;

   // cycles for the two register stages plus margin
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_LIMIT   = 2000;

   typedef struct packed {
      logic [63:0] result;
      flags_type   flags;
   } alu_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_kind = KIND_ADD;
   logic [31:0] req_src = '0;
   logic [31:0] req_dest = '0;
   logic [1:0]  req_size_sel = SIZE_8;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_result;
   logic        rsp_cf;
   logic        rsp_pf;
   logic        rsp_zf;
   logic        rsp_sf;
   logic        rsp_of;

   // predicted flag register, advanced once per accepted item
   flags_type       flag_reg = '0;
   alu_outcome_type pending_results[$];
   int unsigned     error_count = 0;

   // idling switches: sender side used by the stimulus process only,
   // receiver side changed with nonblocking writes
   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   int unsigned stall_left = 0;

   x86_integer_alu_with_flags dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_src      (req_src),
      .req_dest     (req_dest),
      .req_size_sel (req_size_sel),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result   (rsp_result),
      .rsp_cf       (rsp_cf),
      .rsp_pf       (rsp_pf),
      .rsp_zf       (rsp_zf),
      .rsp_sf       (rsp_sf),
      .rsp_of       (rsp_of)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // operand width for shifts and multiplies; selector 3 counts as 32 bits
   function automatic int unsigned width_of(input logic [1:0] size_sel);
      int unsigned w;
      w = (size_sel == SIZE_8) ? 8 : (size_sel == SIZE_16) ? 16 : 32;
      if (w > ALU_WORD) w = ALU_WORD;
      return w;
   endfunction

   // parity of the low byte, zero and sign of the width-limited value
   function automatic void update_pzs(input logic [63:0] v, input int unsigned w);
      logic [63:0] m;
      m = (64'd1 << w) - 64'd1;
      flag_reg.pf = ~^v[7:0];
      flag_reg.zf = ((v & m) == 64'd0);
      flag_reg.sf = v[w - 1];
   endfunction

   // expected result of one item; updates the predicted flags as the block would
   function automatic alu_outcome_type predict_alu(input logic [3:0] kind,
         input logic [31:0] src, input logic [31:0] dest, input logic [1:0] size_sel);
      alu_outcome_type res;
      int unsigned  w;
      logic [63:0]  m, a, b, y, upper, wide, hi;
      logic [31:0]  res32;
      logic         cin, s, big;
      w = width_of(size_sel);
      m = (64'd1 << w) - 64'd1;
      res.result = '0;
      case (kind)
         KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBB: begin
            a = {32'd0, src};
            b = {32'd0, dest};
            cin = (kind == KIND_ADC || kind == KIND_SBB) ? flag_reg.cf : 1'b0;
            if (kind == KIND_ADD || kind == KIND_ADC) begin
               wide = a + b + 64'(cin);
               res32 = wide[31:0];
               flag_reg.cf = wide[32];
               flag_reg.of = ~(src[31] ^ dest[31]) & (src[31] ^ res32[31]);
            end else begin
               wide = b - a - 64'(cin);
               res32 = wide[31:0];
               // borrow when the subtrahend plus borrow-in exceeds dest
               flag_reg.cf = (b < a + 64'(cin));
               flag_reg.of = (src[31] ^ dest[31]) & (dest[31] ^ res32[31]);
            end
            update_pzs({32'd0, res32}, ALU_WORD);
            res.result = {32'd0, res32};
         end
         KIND_AND, KIND_OR, KIND_XOR: begin
            res32 = (kind == KIND_AND) ? (src & dest) :
                    (kind == KIND_OR)  ? (src | dest) : (src ^ dest);
            flag_reg.cf = 1'b0;
            flag_reg.of = 1'b0;
            update_pzs({32'd0, res32}, ALU_WORD);
            res.result = {32'd0, res32};
         end
         KIND_SHL, KIND_SHR, KIND_SAL, KIND_SAR: begin
            y = {32'd0, dest} & m;
            upper = {32'd0, dest} & ~m;
            // a zero count leaves the field and carry alone
            if (src != 32'd0) begin
               if (kind == KIND_SHL || kind == KIND_SAL) begin
                  if (src < w) begin
                     flag_reg.cf = y[w - src];
                     y = (y << src) & m;
                  end else begin
                     flag_reg.cf = (src == w) ? y[0] : 1'b0;
                     y = '0;
                  end
               end else if (kind == KIND_SHR) begin
                  if (src < w) begin
                     flag_reg.cf = y[src - 1];
                     y = y >> src;
                  end else begin
                     flag_reg.cf = (src == w) ? y[w - 1] : 1'b0;
                     y = '0;
                  end
               end else begin
                  s = y[w - 1];
                  if (src < w) begin
                     flag_reg.cf = y[src - 1];
                     y = (y >> src) | (s ? (m & ~(m >> src)) : 64'd0);
                  end else begin
                     flag_reg.cf = s;
                     y = s ? m : 64'd0;
                  end
               end
            end
            update_pzs(y, w);
            res.result = upper | y;
         end
         KIND_MUL, KIND_IMUL: begin
            a = {32'd0, src} & m;
            b = {32'd0, dest} & m;
            if (kind == KIND_MUL) begin
               wide = a * b;
               big = ((wide >> w) != 64'd0);
            end else begin
               if (a[w - 1]) a = a | ~m;
               if (b[w - 1]) b = b | ~m;
               wide = a * b;
               // high half significant unless it is the sign extension of the low half
               hi = wide >> (w - 1);
               big = !(hi == 64'd0 || hi == ({64{1'b1}} >> (w - 1)));
            end
            flag_reg.cf = big;
            flag_reg.of = big;
            res.result = wide;
         end
         default: begin
            // spare kinds: zero result, flags as they were
         end
      endcase
      res.flags = flag_reg;
      return res;
   endfunction

   // mostly back to back, sometimes a short gap, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // operands biased toward the corners of the 32-bit range
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   // shift counts mostly inside the width, with the edges and huge counts
   function automatic logic [31:0] pick_count(input int unsigned w);
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return w;
         2: return $urandom_range(w + 1, 40);
         3: return $urandom();
         default: return $urandom_range(1, w - 1);
      endcase
   endfunction

   // drive one item, wait for its acceptance and record its expected result
   task automatic send_op(input logic [3:0] kind, input logic [31:0] src,
         input logic [31:0] dest, input logic [1:0] size_sel);
      int unsigned gap;
      gap = sender_idle ? idle_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_src      <= src;
      req_dest     <= dest;
      req_size_sel <= size_sel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_alu(kind, src, dest, size_sel));
   endtask

   task automatic send_random(input bit carry_chain);
      logic [3:0]  kind;
      logic [1:0]  size_sel;
      logic [31:0] src;
      if (carry_chain)
         kind = 4'($urandom_range(KIND_ADD, KIND_SBB));
      else if ($urandom_range(0, 99) < 95)
         kind = 4'($urandom_range(KIND_ADD, KIND_IMUL));
      else
         kind = 4'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      size_sel = 2'($urandom_range(0, 3));
      if (kind >= KIND_SHL && kind <= KIND_SAR)
         src = pick_count(width_of(size_sel));
      else
         src = pick_operand();
      send_op(kind, src, pick_operand(), size_sel);
   endtask

   // hold the sender off until every outstanding item has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_arith_directed();
      send_op(KIND_ADD, 32'h0000_0000, 32'h0000_0000, SIZE_32);  // zero result
      send_op(KIND_ADD, 32'h0000_0001, 32'h7fff_ffff, SIZE_32);  // signed overflow
      send_op(KIND_ADD, 32'h0000_0001, 32'hffff_ffff, SIZE_32);  // carry out, zero
      send_op(KIND_ADC, 32'h0000_0000, 32'h0000_0000, SIZE_32);  // carry in alone
      send_op(KIND_ADD, 32'h0000_0001, 32'hffff_ffff, SIZE_32);
      send_op(KIND_ADC, 32'hffff_ffff, 32'hffff_ffff, SIZE_32);  // carry in on all ones
      send_op(KIND_SUB, 32'h0000_0001, 32'h0000_0000, SIZE_32);  // borrow
      send_op(KIND_SBB, 32'h0000_0000, 32'h0000_0000, SIZE_32);  // borrow in alone
      send_op(KIND_SUB, 32'h0000_0001, 32'h8000_0000, SIZE_32);  // signed overflow
   endtask

   task automatic test_logic_directed();
      send_op(KIND_AND, 32'hffff_ffff, 32'h0000_0000, SIZE_32);
      send_op(KIND_OR,  32'h8000_0000, 32'h0000_0003, SIZE_16);
      send_op(KIND_XOR, 32'ha5a5_a5a5, 32'hffff_ffff, SIZE_8);
   endtask

   task automatic test_shift_directed();
      send_op(KIND_SHL, 32'd0,   32'hffff_ff80, SIZE_8);     // zero count keeps carry
      send_op(KIND_SHL, 32'd8,   32'h1234_5601, SIZE_8);     // count equals width
      send_op(KIND_SHR, 32'd16,  32'hdead_8000, SIZE_16);
      send_op(KIND_SAR, 32'd200, 32'h0000_0080, SIZE_8);     // count past width, negative
      send_op(KIND_SAL, 32'd33,  32'hffff_ffff, SIZE_32);    // count past width
      send_op(KIND_SAR, 32'd5,   32'h8000_0000, SIZE_32);
      send_op(KIND_SHR, 32'd31,  32'hffff_ffff, SIZE_WIDE);  // selector 3 as 32 bits
      send_op(KIND_SHL, 32'd1,   32'hffff_4000, SIZE_16);    // upper dest bits kept
      send_op(KIND_SAR, 32'hffff_ffff, 32'h0000_7fff, SIZE_16);
   endtask

   task automatic test_mul_directed();
      send_op(KIND_MUL,  32'h0000_00ff, 32'h0000_00ff, SIZE_8);
      send_op(KIND_IMUL, 32'h0000_0080, 32'h0000_0080, SIZE_8);     // -128 squared
      send_op(KIND_IMUL, 32'h0000_ffff, 32'h0000_ffff, SIZE_16);    // -1 squared
      send_op(KIND_MUL,  32'hffff_ffff, 32'hffff_ffff, SIZE_32);
      send_op(KIND_IMUL, 32'h8000_0000, 32'h0000_0001, SIZE_WIDE);
   endtask

   task automatic test_spare_kinds();
      for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
         send_op(4'(k), $urandom(), $urandom(), 2'($urandom_range(0, 3)));
   endtask

   task automatic test_random_mix(input int unsigned count);
      repeat (count) send_random(1'b0);
   endtask

   // full rate on both sides, so every item meets the carry of the one just ahead
   task automatic test_back_to_back(input int unsigned count);
      sender_idle = 1'b0;
      receiver_idle <= 1'b0;
      repeat (count) send_random(1'b0);
      sender_idle = 1'b1;
      receiver_idle <= 1'b1;
   endtask

   // add/adc/sub/sbb chains started from a drained pipeline
   task automatic test_carry_chain(input int unsigned count);
      wait_for_results();
      repeat (count) send_random(1'b1);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   // receiver readiness: random stalls, occasionally long
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(7, 29);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // every accepted result against the oldest prediction
   always @(posedge clock) begin : result_check
      alu_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: result %h", rsp_result);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result", want.result, rsp_result);
            check_field("cf", 64'(want.flags.cf), 64'(rsp_cf));
            check_field("pf", 64'(want.flags.pf), 64'(rsp_pf));
            check_field("zf", 64'(want.flags.zf), 64'(rsp_zf));
            check_field("sf", 64'(want.flags.sf), 64'(rsp_sf));
            check_field("of", 64'(want.flags.of), 64'(rsp_of));
         end
      end
   end

   initial begin : stimulus
      int unsigned waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_arith_directed();
      test_logic_directed();
      test_shift_directed();
      test_mul_directed();
      test_spare_kinds();
      test_random_mix(1200);
      test_back_to_back(200);
      test_carry_chain(200);

      // let the last items come back, then idle for SETTLE_CYCLES to catch strays
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d expected result items never arrived", pending_results.size());
         error_count += pending_results.size();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin : watchdog
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
